// File: rtl/core/lmfs_pkg.sv
// Shared types and constants for the LED matrix frame serializer.
package lmfs_pkg;

    localparam int MATRICES   = 4;
    localparam int ROWS       = 8;
    localparam int STORE_COLS = 32;
    localparam int HDR_BITS   = 10;
    localparam int CMD_BITS   = 12;
    localparam int FRAME_LEN  = HDR_BITS + MATRICES * ROWS * 8;
    localparam int CNT_W      = $clog2(FRAME_LEN);
    localparam int COL_W      = $clog2(STORE_COLS);
    localparam int ADDR_W     = 3;

    localparam logic [ADDR_W-1:0] ADDR_WRITE_HEADER = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_BRIGHT_BASE  = 3'd4;

    localparam logic [9:0]  WRITE_HEADER_RST = 10'd640;
    localparam logic [11:0] BRIGHT_BASE_RST  = 12'd2368;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_SET_PIX = 3'd1,
        CMD_WR_COL  = 3'd2,
        CMD_BRIGHT  = 3'd3,
        CMD_REFRESH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CMD   = 2'd1,
        MODE_FRAME = 2'd2
    } t_mode;

    // Result flags of one request.
    typedef struct packed {
        logic select_active;
        logic bit_valid;
        logic data_bit;
        logic transfer_last;
        logic rejected;
    } t_res;

    // Request in flight between store read and write back.
    typedef struct packed {
        t_cmd             cmd;
        logic [COL_W-1:0] col;
        logic [2:0]       row;
        logic             pixel_on;
        logic [7:0]       pattern;
        logic             frame_rd;
        logic             oob;
        logic [2:0]       frow;
        t_res             res;
    } t_s2;

endpackage

// File: rtl/core/led_matrix_frame_serializer.sv
// Top level: frame store, serializer control and result pipeline.
//
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_stall   | cmd column row pixel_on pattern level
//  result  | out       | o_valid / i_stall   | select_active bit_valid data_bit
//          |           |                     | transfer_last busy_res rejected
//  config  | in        | APB psel / penable  | write_header bright_base
//
// One request per cycle while the result is not stalled; a request passes the store read, then the result register.
// The frame store is a 32x8 RAM with registered read; read-modify-write of set pixel
// is forwarded when the next request reads the column being written back.
// Reset is synchronous; per-column valid flops make the store read as zero after reset.
// A stalled result holds; a new request is taken as long as the middle stage can move.
module led_matrix_frame_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [4:0]  i_column,
    input  logic [2:0]  i_row,
    input  logic        i_pixel_on,
    input  logic [7:0]  i_pattern,
    input  logic [3:0]  i_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_select_active,
    output logic        o_bit_valid,
    output logic        o_data_bit,
    output logic        o_transfer_last,
    output logic        o_busy_res,
    output logic        o_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lmfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lmfs_pkg::*;

    logic [7:0]            mem [STORE_COLS];
    logic [STORE_COLS-1:0] r_vld;
    logic [7:0]            r_rdata;
    logic                  r_rvld;
    logic                  r_fwd;
    logic [7:0]            r_fwd_data;

    logic [9:0]            r_write_header;
    logic [11:0]           r_bright_base;

    t_mode                 r_mode, n_mode;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [11:0]           r_shift, n_shift;

    logic                  r_s2_v;
    t_s2                   r_s2;
    logic                  r_out_v;
    t_res                  r_out;

    t_cmd                  cmd;
    logic                  in_acc, busy, is_last, s2_adv, s2_wr, out_acc;
    t_s2                   s1;
    t_res                  s2_res;
    logic [COL_W-1:0]      rd_addr;
    logic [CNT_W-1:0]      fidx;
    logic [15:0]           fcol;
    logic [3:0]            bidx;
    logic [7:0]            rd, wdata;
    logic                  cfg_wr;

    assign cmd     = t_cmd'(i_cmd);
    assign busy    = r_mode != MODE_IDLE;
    assign out_acc = r_out_v && !i_stall;
    assign s2_adv  = r_s2_v && (!r_out_v || !i_stall);
    assign o_stall = r_s2_v && !s2_adv;
    assign in_acc  = i_valid && !o_stall;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2]) begin
            prdata = 32'(r_bright_base);
        end else begin
            prdata = 32'(r_write_header);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_header <= WRITE_HEADER_RST;
            r_bright_base  <= BRIGHT_BASE_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_bright_base <= pwdata[11:0];
            end else begin
                r_write_header <= pwdata[9:0];
            end
        end
    end

    // Serializer position
    always_comb begin
        is_last = 1'b0;
        if (r_mode == MODE_CMD) begin
            is_last = r_cnt == CNT_W'(CMD_BITS - 1);
        end else if (r_mode == MODE_FRAME) begin
            is_last = r_cnt == CNT_W'(FRAME_LEN - 1);
        end
    end

    assign fidx = r_cnt - CNT_W'(HDR_BITS);
    assign fcol = 16'({fidx >> 6, fidx[2:0]});

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        if (in_acc) begin
            unique case (cmd)
                CMD_TICK: begin
                    if (busy) begin
                        if (is_last) begin
                            n_mode = MODE_IDLE;
                            n_cnt  = '0;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end
                CMD_BRIGHT: begin
                    if (!busy) begin
                        n_shift = r_bright_base + {7'd0, i_level, 1'b0};
                        n_mode  = MODE_CMD;
                        n_cnt   = '0;
                    end
                end
                CMD_REFRESH: begin
                    if (!busy) begin
                        n_shift = {2'b00, r_write_header};
                        n_mode  = MODE_FRAME;
                        n_cnt   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Per-request outputs of the first stage
    always_comb begin
        s1          = '0;
        s1.cmd      = cmd;
        s1.col      = i_column;
        s1.row      = i_row;
        s1.pixel_on = i_pixel_on;
        s1.pattern  = i_pattern;
        s1.res.select_active = busy;
        rd_addr     = i_column;
        bidx        = '0;
        unique case (cmd)
            CMD_TICK: begin
                if (busy) begin
                    s1.res.bit_valid     = 1'b1;
                    s1.res.transfer_last = is_last;
                    if (r_mode == MODE_CMD) begin
                        bidx = 4'(CMD_BITS - 1) - r_cnt[3:0];
                        s1.res.data_bit = r_shift[bidx];
                    end else if (r_cnt < CNT_W'(HDR_BITS)) begin
                        bidx = 4'(HDR_BITS - 1) - r_cnt[3:0];
                        s1.res.data_bit = r_shift[bidx];
                    end else begin
                        s1.frame_rd = 1'b1;
                        s1.frow     = fidx[5:3];
                        s1.oob      = fcol >= 16'(STORE_COLS);
                        rd_addr     = fcol[COL_W-1:0];
                    end
                end
            end
            CMD_BRIGHT, CMD_REFRESH: begin
                s1.res.rejected      = busy;
                s1.res.select_active = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Frame store read, forwarding and write back
    assign rd = r_fwd ? r_fwd_data : (r_rvld ? r_rdata : 8'd0);
    assign s2_wr = r_s2_v && (r_s2.cmd == CMD_SET_PIX || r_s2.cmd == CMD_WR_COL);

    always_comb begin
        if (r_s2.cmd == CMD_WR_COL) begin
            wdata = r_s2.pattern;
        end else begin
            wdata = rd | (8'(r_s2.pixel_on) << r_s2.row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata    <= mem[rd_addr];
            r_rvld     <= r_vld[rd_addr];
            r_fwd      <= s2_adv && s2_wr && (r_s2.col == rd_addr);
            r_fwd_data <= wdata;
        end
        if (s2_adv && s2_wr) begin
            mem[r_s2.col] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s2_adv && s2_wr) begin
            r_vld[r_s2.col] <= 1'b1;
        end
    end

    // Control state and pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            if (in_acc) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_out_v <= 1'b1;
            end else if (out_acc) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        s2_res = r_s2.res;
        if (r_s2.frame_rd) begin
            s2_res.data_bit = !r_s2.oob && rd[r_s2.frow];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2 <= s1;
        end
        if (s2_adv) begin
            r_out <= s2_res;
        end
    end

    assign o_valid         = r_out_v;
    assign o_select_active = r_out.select_active;
    assign o_bit_valid     = r_out.bit_valid;
    assign o_data_bit      = r_out.data_bit;
    assign o_transfer_last = r_out.transfer_last;
    assign o_busy_res      = r_out.select_active;
    assign o_rejected      = r_out.rejected;

    // Checks
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_IDLE |-> r_cnt == '0)
        else $error("counter not cleared while idle");

    a_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.transfer_last |-> r_out.bit_valid && r_out.select_active)
        else $error("last bit without a bit in a transfer");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.rejected |-> r_out.select_active && !r_out.bit_valid)
        else $error("reject outside a transfer");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s2_v && r_out_v)
        else $error("input stalled with room in the pipeline");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && cmd == CMD_TICK && is_last |=> r_mode == MODE_IDLE)
        else $error("transfer did not end after last bit");

endmodule
